### rtl/core/sfsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsp_pkg
// Types, character codes and constants shared by the scan format specifier
// parser modules.
// ----------------------------------------------------------------------------
package sfsp_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_AFTER_STAR = 4'd1,
    PH_DIGITS     = 4'd2,
    PH_AFTER_H    = 4'd3,
    PH_AFTER_L    = 4'd4,
    PH_CONV       = 4'd5,
    PH_SET_OPEN   = 4'd6,
    PH_SET_CARET  = 4'd7,
    PH_SET_BODY   = 4'd8
  } sfsp_phase_t;

  // size option codes
  localparam logic [2:0] SZ_NORMAL  = 3'd0;
  localparam logic [2:0] SZ_CHAR    = 3'd1;
  localparam logic [2:0] SZ_SHORT   = 3'd2;
  localparam logic [2:0] SZ_LONG    = 3'd3;
  localparam logic [2:0] SZ_LLONG   = 3'd4;
  localparam logic [2:0] SZ_DOUBLE  = 3'd5;
  localparam logic [2:0] SZ_LDOUBLE = 3'd6;
  localparam logic [2:0] SZ_WIDE    = 3'd7;

  // width limits
  localparam logic [30:0] WIDTH_MAX    = 31'h7FFF_FFFF;
  localparam logic [30:0] WIDTH_LIM_LO = 31'd214748364;  // digits 0..7
  localparam logic [30:0] WIDTH_LIM_HI = 31'd214748363;  // digits 8..9

  localparam logic [7:0] BAD_CODE = 8'hFF;

  // everything except tab, newline, vt, ff, cr and space
  localparam logic [63:0] STR_SET0 = 64'hFFFF_FFFE_FFFF_C1FF;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_UG    = 8'h47;
  localparam logic [7:0] CH_UL    = 8'h4C;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;

  // item held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } sfsp_item_t;

  // parser state
  typedef struct packed {
    sfsp_phase_t  phase;
    logic         suppress;
    logic         width_seen;
    logic [30:0]  width_acc;
    logic [2:0]   size_sel;
    logic [255:0] char_set;
    logic         negate;
    logic [7:0]   range_start;
    logic         range_valid;
    logic         dash_waiting;
    logic [7:0]   conv_code;
  } sfsp_state_t;

  localparam sfsp_state_t STATE_RESET = '{
    phase:        PH_START,
    suppress:     1'b0,
    width_seen:   1'b0,
    width_acc:    WIDTH_MAX,
    size_sel:     SZ_NORMAL,
    char_set:     256'd0,
    negate:       1'b0,
    range_start:  8'd0,
    range_valid:  1'b0,
    dash_waiting: 1'b0,
    conv_code:    8'd0
  };

  // one result item
  typedef struct packed {
    logic [7:0]   conversion;
    logic         suppress;
    logic         width_given;
    logic [30:0]  width_value;
    logic [2:0]   size_option;
    logic [255:0] set_bits;
  } sfsp_result_t;

  // parser to output stage
  typedef struct packed {
    logic         emit;
    sfsp_result_t res;
  } sfsp_res_t;

endpackage

### rtl/core/sfsp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsp_in_stage
// Input register: holds one character item until the parser consumes it.
// ----------------------------------------------------------------------------
module sfsp_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_ch,
  input  logic                take,
  output sfsp_pkg::sfsp_item_t item
);
  import sfsp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] ch_r;

  // room when empty or when the held item leaves this cycle
  assign in_ready = !valid_r || take;

  // valid flag
  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r <= in_ch;
    end
  end

  assign item.valid = valid_r;
  assign item.ch    = ch_r;

endmodule

### rtl/core/sfsp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsp_parse
// Specifier state register and the one-character step logic.
// ----------------------------------------------------------------------------
module sfsp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           ch,
  input  logic                 take,
  output sfsp_pkg::sfsp_res_t  res
);
  import sfsp_pkg::*;

  typedef struct packed {
    sfsp_state_t st;
    logic        emit;
  } step_t;

  sfsp_state_t state_r;
  sfsp_state_t state_nxt;
  step_t       step;

  function automatic logic is_digit(input logic [7:0] x);
    is_digit = (x >= CH_ZERO) && (x <= CH_NINE);
  endfunction

  // c, s and [ take no size or l (wide)
  function automatic sfsp_state_t char_like(input sfsp_state_t s);
    sfsp_state_t r;
    r = s;
    if (s.size_sel == SZ_LONG) begin
      r.size_sel = SZ_WIDE;
    end else if (s.size_sel != SZ_NORMAL) begin
      r.conv_code = BAD_CODE;
    end
    return r;
  endfunction

  // conversion letter
  function automatic step_t do_convert(input sfsp_state_t s, input logic [7:0] x);
    step_t r;
    r.st = s;
    r.emit = 1'b1;
    r.st.conv_code = x;
    case (x)
      CH_D, CH_I, CH_U, CH_O, CH_X, CH_UX: begin
        if (s.size_sel == SZ_LDOUBLE) r.st.conv_code = BAD_CODE;
      end
      CH_A, CH_F, CH_E, CH_UE, CH_G, CH_UG: begin
        if (s.size_sel == SZ_CHAR || s.size_sel == SZ_SHORT || s.size_sel == SZ_LLONG) begin
          r.st.conv_code = BAD_CODE;
        end else if (s.size_sel == SZ_LONG) begin
          r.st.size_sel = SZ_DOUBLE;
        end
      end
      CH_P: begin
        r.st.size_sel  = SZ_LONG;
        r.st.conv_code = CH_X;
      end
      CH_C: begin
        r.st = char_like(r.st);
      end
      CH_S: begin
        r.st = char_like(r.st);
        r.st.char_set = {{192{1'b1}}, STR_SET0};
      end
      CH_N: begin
      end
      CH_LBRK: begin
        r.st = char_like(r.st);
        r.st.negate       = 1'b0;
        r.st.range_valid  = 1'b0;
        r.st.dash_waiting = 1'b0;
        r.st.phase        = PH_SET_OPEN;
        r.emit            = 1'b0;
      end
      default: begin
        r.st.conv_code = BAD_CODE;
      end
    endcase
    return r;
  endfunction

  // size prefix or conversion letter
  function automatic step_t size_or_conv(input sfsp_state_t s, input logic [7:0] x);
    step_t r;
    r.st = s;
    r.emit = 1'b0;
    if (x == CH_H) begin
      r.st.size_sel = SZ_SHORT;
      r.st.phase    = PH_AFTER_H;
    end else if (x == CH_L) begin
      r.st.size_sel = SZ_LONG;
      r.st.phase    = PH_AFTER_L;
    end else if (x == CH_UL) begin
      r.st.size_sel = SZ_LDOUBLE;
      r.st.phase    = PH_CONV;
    end else begin
      r = do_convert(s, x);
    end
    return r;
  endfunction

  // first width digit or what follows
  function automatic step_t after_star(input sfsp_state_t s, input logic [7:0] x);
    step_t r;
    r.st = s;
    r.emit = 1'b0;
    if (is_digit(x)) begin
      r.st.width_acc = {27'd0, x[3:0]};
      r.st.phase     = PH_DIGITS;
    end else begin
      r = size_or_conv(s, x);
    end
    return r;
  endfunction

  // closing bracket or end of string inside a set
  function automatic step_t finish_set(input sfsp_state_t s, input logic [7:0] x);
    step_t r;
    r.st = s;
    r.emit = 1'b1;
    if (x == CH_NUL) begin
      r.st.conv_code = BAD_CODE;
    end else if (s.negate) begin
      r.st.char_set = ~s.char_set;
    end
    return r;
  endfunction

  // set body character
  function automatic step_t set_body(input sfsp_state_t s, input logic [7:0] x);
    step_t        r;
    logic [255:0] span;
    r.st = s;
    r.emit = 1'b0;
    // members from the range start up to this character
    for (int i = 0; i < 256; i++) begin
      span[i] = (8'(i) >= s.range_start) && (8'(i) <= x);
    end
    if (s.dash_waiting) begin
      r.st.dash_waiting = 1'b0;
      r.st.range_valid  = 1'b0;
      if (x == CH_NUL || x == CH_RBRK) begin
        r.st.char_set[CH_DASH] = 1'b1;
        r = finish_set(r.st, x);
      end else begin
        r.st.char_set = s.char_set | span;
      end
    end else if (x == CH_DASH && s.range_valid) begin
      r.st.dash_waiting = 1'b1;
    end else if (x == CH_NUL || x == CH_RBRK) begin
      r = finish_set(s, x);
    end else begin
      r.st.char_set[x] = 1'b1;
      r.st.range_start = x;
      r.st.range_valid = 1'b1;
    end
    return r;
  endfunction

  // one step of the parser
  always_comb begin
    logic [30:0] lim;
    logic [34:0] scaled;
    step.st   = state_r;
    step.emit = 1'b0;
    lim    = (ch[3:0] <= 4'd7) ? WIDTH_LIM_LO : WIDTH_LIM_HI;
    scaled = {1'b0, state_r.width_acc, 3'b000} + {3'b000, state_r.width_acc, 1'b0}
           + {31'd0, ch[3:0]};
    case (state_r.phase)
      PH_AFTER_STAR: begin
        step = after_star(state_r, ch);
      end
      PH_DIGITS: begin
        if (is_digit(ch)) begin
          step.st.width_acc = (state_r.width_acc > lim) ? WIDTH_MAX : scaled[30:0];
        end else if (state_r.width_acc == 31'd0) begin
          step.st.conv_code = BAD_CODE;
          step.emit         = 1'b1;
        end else begin
          step.st.width_seen = 1'b1;
          step = size_or_conv(step.st, ch);
        end
      end
      PH_AFTER_H: begin
        if (ch == CH_H) begin
          step.st.size_sel = SZ_CHAR;
          step.st.phase    = PH_CONV;
        end else begin
          step = do_convert(state_r, ch);
        end
      end
      PH_AFTER_L: begin
        if (ch == CH_L) begin
          step.st.size_sel = SZ_LLONG;
          step.st.phase    = PH_CONV;
        end else begin
          step = do_convert(state_r, ch);
        end
      end
      PH_CONV: begin
        step = do_convert(state_r, ch);
      end
      PH_SET_OPEN: begin
        if (ch == CH_CARET) begin
          step.st.negate = 1'b1;
          step.st.phase  = PH_SET_CARET;
        end else if (ch == CH_RBRK) begin
          step.st.char_set[CH_RBRK] = 1'b1;
          step.st.phase = PH_SET_BODY;
        end else begin
          step.st.phase = PH_SET_BODY;
          step = set_body(step.st, ch);
        end
      end
      PH_SET_CARET: begin
        step.st.phase = PH_SET_BODY;
        if (ch == CH_RBRK) begin
          step.st.char_set[CH_RBRK] = 1'b1;
        end else begin
          step = set_body(step.st, ch);
        end
      end
      PH_SET_BODY: begin
        step = set_body(state_r, ch);
      end
      default: begin
        // start of a specifier, or a phase with no meaning
        step.st = STATE_RESET;
        if (ch == CH_PCT) begin
          step.st.conv_code = CH_PCT;
          step.emit         = 1'b1;
        end else if (ch == CH_STAR) begin
          step.st.suppress = 1'b1;
          step.st.phase    = PH_AFTER_STAR;
        end else begin
          step = after_star(STATE_RESET, ch);
        end
      end
    endcase
  end

  // result fields and next state
  always_comb begin
    res.emit                = step.emit;
    res.res.conversion      = step.st.conv_code;
    res.res.suppress        = step.st.suppress;
    res.res.width_given     = step.st.width_seen;
    res.res.width_value     = step.st.width_acc;
    res.res.size_option     = step.st.size_sel;
    res.res.set_bits        = step.st.char_set;
    state_nxt = state_r;
    if (take) begin
      state_nxt = step.emit ? STATE_RESET : step.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a finished specifier leaves the parser ready for the next one
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (take && step.emit) |=> (state_r.phase == PH_START && state_r.width_acc == WIDTH_MAX))
    else $error("parser state not cleared after result");

  // a given width is never zero
  a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (take && step.emit && step.st.width_seen) |-> (step.st.width_acc != 31'd0))
    else $error("width_given with zero width");

  // a pending dash only lives inside a set body
  a_dash_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.dash_waiting |-> (state_r.phase == PH_SET_BODY))
    else $error("dash pending outside set body");

endmodule

### rtl/core/sfsp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsp_out_stage
// Result register: holds one finished result item until the receiver takes it.
// ----------------------------------------------------------------------------
module sfsp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sfsp_pkg::sfsp_result_t res_in,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sfsp_pkg::sfsp_result_t res_out
);
  import sfsp_pkg::*;

  logic         valid_r;
  logic         valid_nxt;
  sfsp_result_t res_r;

  assign can_load = !valid_r || out_ready;

  // valid flag
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!valid_r || out_ready))
    else $error("result register overwritten");

endmodule

### rtl/core/scan_format_spec_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_format_spec_parser_core
// Parses the characters after a percent sign in a scan format, one per item,
// and gives one result item per specifier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_ch carries one format character per
//   item, starting with the character right after the percent sign; zero is
//   end of string. The result channel out_valid/out_ready carries the
//   conversion code, flags, width, size option and the 256-bit accepted set.
//   Throughput is one character per cycle unless a result waits for room
//   in the result register. Each character goes through an input register,
//   combinational parse logic and the result register, which drives
//   out_valid. Characters that end no specifier give no result item.
//   While the receiver stalls, characters that produce no result keep being
//   consumed; a character that would produce one waits in the input register
//   and in_ready stays low until the result register has room again.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the start of a specifier.
// ----------------------------------------------------------------------------
module scan_format_spec_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_ch,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_conversion,
  output logic         out_suppress,
  output logic         out_width_given,
  output logic [30:0]  out_width_value,
  output logic [2:0]   out_size_option,
  output logic [63:0]  out_set_bits_0,
  output logic [63:0]  out_set_bits_1,
  output logic [63:0]  out_set_bits_2,
  output logic [63:0]  out_set_bits_3
);
  import sfsp_pkg::*;

  sfsp_item_t   item;
  sfsp_res_t    res;
  sfsp_result_t res_out;
  logic         can_load;
  logic         take;
  logic         load;

  // consume the held character unless its result has nowhere to go
  assign take = item.valid && (!res.emit || can_load);
  assign load = take && res.emit;

  sfsp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .take     (take),
    .item     (item)
  );

  sfsp_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .ch    (item.ch),
    .take  (take),
    .res   (res)
  );

  sfsp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res_in    (res.res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  // result fields
  assign out_conversion  = res_out.conversion;
  assign out_suppress    = res_out.suppress;
  assign out_width_given = res_out.width_given;
  assign out_width_value = res_out.width_value;
  assign out_size_option = res_out.size_option;
  assign out_set_bits_0  = res_out.set_bits[63:0];
  assign out_set_bits_1  = res_out.set_bits[127:64];
  assign out_set_bits_2  = res_out.set_bits[191:128];
  assign out_set_bits_3  = res_out.set_bits[255:192];

endmodule
